@@ sv/rsl_pkg.sv @@
// ----------------------------------------------------------------------------
// Radial spotlight luma package
// Shared constants for the radial spotlight luminance block.
// ----------------------------------------------------------------------------
package rsl_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = CFG_IDX_W'(1);

  // Squared distance at and beyond which the attenuation is capped (160 px).
  localparam int FAR_D2 = 25600;
  localparam int D2S_W  = 15;

  // Square root of the near squared distance shifted left by RAD_SHIFT.
  localparam int RAD_SHIFT  = 8;
  localparam int RAD_W      = 24;
  localparam int SQRT_STEPS = 12;
  localparam int ROOT_W     = 12;
  localparam int REM_W      = 14;

  // Gain is (GAIN_DEN - distance) / GAIN_DEN with the distance in Q8.4.
  localparam int DIST_CAP = 2560;
  localparam int GAIN_DEN = 3200;
  localparam int GAIN_W   = 12;

  // GAIN_DEN = 2**DIV_SHIFT * DIV_REST.
  localparam int DIV_SHIFT = 7;
  localparam int DIV_REST  = 25;

  localparam int QUEUE_DEPTH = 4;

endpackage

@@ sv/rsl_in_if.sv @@
// ----------------------------------------------------------------------------
// Radial spotlight pixel channel
// Valid/ready channel that carries one pixel per beat.
// ----------------------------------------------------------------------------
interface rsl_in_if #(
  parameter int COORD_BITS = 12,
  parameter int LUM_BITS   = 16
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pix_x;
  logic [COORD_BITS-1:0] pix_y;
  logic [LUM_BITS-1:0]   lum_in;

  modport source (output valid, output pix_x, output pix_y, output lum_in, input ready);
  modport sink (input valid, input pix_x, input pix_y, input lum_in, output ready);
endinterface

@@ sv/rsl_out_if.sv @@
// ----------------------------------------------------------------------------
// Radial spotlight result channel
// Valid/ready channel that carries one attenuated luminance per beat.
// ----------------------------------------------------------------------------
interface rsl_out_if #(
  parameter int LUM_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [LUM_BITS-1:0] lum_out;

  modport source (output valid, output lum_out, input ready);
  modport sink (input valid, input lum_out, output ready);
endinterface

@@ sv/rsl_ram.sv @@
// ----------------------------------------------------------------------------
// Radial spotlight queue
// Small register queue that decouples the front and back pipelines.
// ----------------------------------------------------------------------------
module rsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(DEPTH))
    else $error("Queue fill count exceeds its depth.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("Queue fill count did not follow a lone push.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (cnt_q == $past(cnt_q) - CW'(1)))
    else $error("Queue fill count did not follow a lone pop.");

endmodule

@@ sv/rsl_front.sv @@
// ----------------------------------------------------------------------------
// Radial spotlight front end
// Accepts pixels, forms the squared distance and marks far pixels.
// ----------------------------------------------------------------------------
module rsl_front #(
  parameter int COORD_BITS = 12,
  parameter int LUM_BITS   = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  rsl_in_if.sink                    pix_i,
  input  logic [COORD_BITS-1:0]     center_x_i,
  input  logic [COORD_BITS-1:0]     center_y_i,
  output logic                      q_valid_o,
  input  logic                      q_ready_i,
  output logic [LUM_BITS-1:0]       q_lum_o,
  output logic                      q_far_o,
  output logic [rsl_pkg::D2S_W-1:0] q_d2s_o
);
  import rsl_pkg::*;

  localparam int D2W = 2 * COORD_BITS + 1;

  logic                    adv;
  logic                    v1_q, v2_q, v3_q;
  logic [COORD_BITS-1:0]   dx_d, dy_d;
  logic [COORD_BITS-1:0]   dx_q, dy_q;
  logic [2*COORD_BITS-1:0] sqx_q, sqy_q;
  logic [D2W-1:0]          d2;
  logic [LUM_BITS-1:0]     lum1_q, lum2_q, lum3_q;
  logic [D2S_W-1:0]        d2s_q;
  logic                    far_q;

  assign adv         = !v3_q || q_ready_i;
  assign pix_i.ready = adv;

  assign dx_d = (pix_i.pix_x >= center_x_i) ? pix_i.pix_x - center_x_i
                                             : center_x_i - pix_i.pix_x;
  assign dy_d = (pix_i.pix_y >= center_y_i) ? pix_i.pix_y - center_y_i
                                             : center_y_i - pix_i.pix_y;
  assign d2   = D2W'(sqx_q) + D2W'(sqy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= pix_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      lum1_q <= pix_i.lum_in;
      sqx_q  <= (2*COORD_BITS)'(dx_q) * (2*COORD_BITS)'(dx_q);
      sqy_q  <= (2*COORD_BITS)'(dy_q) * (2*COORD_BITS)'(dy_q);
      lum2_q <= lum1_q;
      d2s_q  <= d2[D2S_W-1:0];
      far_q  <= (d2 >= D2W'(FAR_D2));
      lum3_q <= lum2_q;
    end
  end

  assign q_valid_o = v3_q;
  assign q_lum_o   = lum3_q;
  assign q_far_o   = far_q;
  assign q_d2s_o   = d2s_q;

endmodule

@@ sv/rsl_back.sv @@
// ----------------------------------------------------------------------------
// Radial spotlight back end
// Square root of the squared distance, gain multiply and division by the gain scale.
// ----------------------------------------------------------------------------
module rsl_back #(
  parameter int LUM_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  output logic                      q_ready_o,
  input  logic [LUM_BITS-1:0]       q_lum_i,
  input  logic                      q_far_i,
  input  logic [rsl_pkg::D2S_W-1:0] q_d2s_i,
  rsl_out_if.source                 res_o
);
  import rsl_pkg::*;

  localparam int PW = LUM_BITS + GAIN_W;
  localparam int XW = PW - DIV_SHIFT;
  localparam int MW = XW - 4;
  localparam int YW = XW + MW;
  localparam longint unsigned M_FULL = (64'd1 << XW) / 64'(DIV_REST);
  localparam logic [MW-1:0] M_REC = MW'(M_FULL);

  logic                  adv;
  logic [SQRT_STEPS:0]   s_vld_q;
  logic [REM_W-1:0]      s_rem_q  [SQRT_STEPS+1];
  logic [ROOT_W-1:0]     s_root_q [SQRT_STEPS+1];
  logic [RAD_W-1:0]      s_rad_q  [SQRT_STEPS+1];
  logic [LUM_BITS-1:0]   s_lum_q  [SQRT_STEPS+1];
  logic                  s_far_q  [SQRT_STEPS+1];
  logic                  p_vld_q, m_vld_q, o_vld_q;
  logic [ROOT_W-1:0]     distc;
  logic [GAIN_W-1:0]     gain;
  logic [PW-1:0]         prod_q;
  logic [XW-1:0]         x_d, x_q;
  logic [YW-1:0]         xm_q;
  logic [LUM_BITS-1:0]   qest;
  logic [XW-1:0]         corr_rem;
  logic [LUM_BITS-1:0]   lum_out_q;

  assign adv       = !o_vld_q || res_o.ready;
  assign q_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= '0;
      p_vld_q <= 1'b0;
      m_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (adv) begin
      s_vld_q <= {s_vld_q[SQRT_STEPS-1:0], q_valid_i};
      p_vld_q <= s_vld_q[SQRT_STEPS];
      m_vld_q <= p_vld_q;
      o_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_rem_q[0]  <= '0;
      s_root_q[0] <= '0;
      s_rad_q[0]  <= {1'b0, q_d2s_i, RAD_SHIFT'(0)};
      s_lum_q[0]  <= q_lum_i;
      s_far_q[0]  <= q_far_i;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [REM_W-1:0] cand;
    logic [REM_W-1:0] trial;
    logic             take;

    assign cand  = {s_rem_q[k][REM_W-3:0], s_rad_q[k][2*(SQRT_STEPS-1-k) +: 2]};
    assign trial = {s_root_q[k], 2'b01};
    assign take  = (cand >= trial);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        s_rem_q[k+1]  <= take ? cand - trial : cand;
        s_root_q[k+1] <= {s_root_q[k][ROOT_W-2:0], take};
        s_rad_q[k+1]  <= s_rad_q[k];
        s_lum_q[k+1]  <= s_lum_q[k];
        s_far_q[k+1]  <= s_far_q[k];
      end
    end
  end

  assign distc    = s_far_q[SQRT_STEPS] ? ROOT_W'(DIST_CAP) : s_root_q[SQRT_STEPS];
  assign gain     = GAIN_W'(GAIN_DEN) - distc;
  assign x_d      = prod_q[PW-1:DIV_SHIFT];
  assign qest     = xm_q[XW +: LUM_BITS];
  assign corr_rem = x_q - XW'(qest) * XW'(DIV_REST);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q    <= PW'(s_lum_q[SQRT_STEPS]) * PW'(gain);
      x_q       <= x_d;
      xm_q      <= YW'(x_d) * YW'(M_REC);
      lum_out_q <= (corr_rem >= XW'(DIV_REST)) ? qest + LUM_BITS'(1) : qest;
    end
  end

  assign res_o.valid   = o_vld_q;
  assign res_o.lum_out = lum_out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_vld_q[SQRT_STEPS] && !s_far_q[SQRT_STEPS]) |->
      (s_root_q[SQRT_STEPS] < ROOT_W'(DIST_CAP)))
    else $error("Near pixel produced a distance at or above the cap.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_vld_q |-> (corr_rem < XW'(2 * DIV_REST)))
    else $error("Reciprocal quotient estimate is off by more than one.");

endmodule

@@ sv/radial_spotlight_luma_top.sv @@
// ----------------------------------------------------------------------------
// Radial spotlight luma top level
// Throughput: one pixel per cycle when the result side does not stall, because
// every stage, square root included, is pipelined and the queue passes one
// beat per cycle.
// Reset clears both centre registers to 0 and empties the pipelines and queue.
// ----------------------------------------------------------------------------
module radial_spotlight_luma_top #(
  parameter int COORD_BITS = 12,
  parameter int LUM_BITS   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rsl_in_if.sink                       pix_i,
  rsl_out_if.source                    res_o,
  input  logic                         cfg_we_i,
  input  logic [rsl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0]        cfg_wdata_i
);
  import rsl_pkg::*;

  localparam int QW = LUM_BITS + 1 + D2S_W;

  logic [COORD_BITS-1:0] center_x_q, center_y_q;
  logic                  f_valid, f_ready;
  logic [LUM_BITS-1:0]   f_lum, b_lum;
  logic                  f_far, b_far;
  logic [D2S_W-1:0]      f_d2s, b_d2s;
  logic                  b_valid, b_ready;
  logic [QW-1:0]         b_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CENTER_X: center_x_q <= cfg_wdata_i;
        CFG_CENTER_Y: center_y_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  rsl_front #(
    .COORD_BITS(COORD_BITS),
    .LUM_BITS  (LUM_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_i),
    .center_x_i(center_x_q),
    .center_y_i(center_y_q),
    .q_valid_o (f_valid),
    .q_ready_i (f_ready),
    .q_lum_o   (f_lum),
    .q_far_o   (f_far),
    .q_d2s_o   (f_d2s)
  );

  rsl_ram #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .push_data_i ({f_lum, f_far, f_d2s}),
    .pop_valid_o (b_valid),
    .pop_ready_i (b_ready),
    .pop_data_o  (b_data)
  );

  assign {b_lum, b_far, b_d2s} = b_data;

  rsl_back #(
    .LUM_BITS(LUM_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(b_valid),
    .q_ready_o(b_ready),
    .q_lum_i  (b_lum),
    .q_far_i  (b_far),
    .q_d2s_i  (b_d2s),
    .res_o    (res_o)
  );

endmodule
